// ===== sv/msgesc_pkg.sv =====
// Shared types, character constants and result helpers for the message escape codec.
// No dependencies; every other codec file imports this package.
package msgesc_pkg;

    localparam int MAX_STRING_LEN = 65535;
    localparam int POS_W          = 17;
    localparam int NUM_SLOTS      = 3;

    localparam logic [POS_W-1:0] POS_CAP = POS_W'(MAX_STRING_LEN + 1);

    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // Configuration register indexes (word index taken from paddr[2])
    localparam logic REG_DECODE_MODE  = 1'b0;
    localparam logic REG_EXTRA_ESCAPE = 1'b1;

    typedef struct packed {
        logic       decode_mode;
        logic [7:0] extra_escape;
    } t_cfg;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             has_byte;
        logic             string_done;
        logic             failed;
        logic [POS_W-1:0] error_position;
    } t_result;

    typedef struct packed {
        logic [1:0]              cnt;
        t_result [NUM_SLOTS-1:0] res;
    } t_batch;

    function automatic t_result data_result(input logic [7:0] b);
        t_result r;
        r                = '0;
        r.out_byte       = b;
        r.has_byte       = 1'b1;
        return r;
    endfunction

    function automatic t_result status_result(input logic fail,
                                              input logic [POS_W-1:0] epos);
        t_result r;
        r                = '0;
        r.string_done    = 1'b1;
        r.failed         = fail;
        r.error_position = epos;
        return r;
    endfunction

endpackage

// ===== sv/message_escape_codec.sv =====
// Message escape codec: byte-stuffing escape / unescape of byte strings.
// An item enters the input register, is decoded into a result batch, and the batch
// is loaded into the result buffer, which offers its first result.
// The result buffer emits one result a cycle while m_axis_tready is high (escaped
// bytes give two, end of string adds one); the next item waits in the input register.
// Reset (i_rst_n, synchronous, active low) clears control and string state, not data.
module message_escape_codec
    import msgesc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // end_of_string
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [8] failed, [25:9] error_position
    output logic [1:0]  m_axis_tuser,   // [0] has_byte, [1] string_done
    output logic        m_axis_tlast    // last_of_run
);

    t_cfg    w_cfg;
    t_batch  w_batch;
    t_result w_res;
    logic    w_load;
    logic    w_buf_free;

    // Register file: mode and extra escape byte, read at every byte
    msgesc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Input register plus decision logic; advance state only when the batch is taken
    msgesc_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_byte     (s_axis_tdata),
        .i_eos      (s_axis_tlast),
        .i_buf_free (w_buf_free),
        .o_load     (w_load),
        .o_batch    (w_batch)
    );

    // Result buffer; a new batch loads in the same cycle the last result leaves
    msgesc_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_batch    (w_batch),
        .o_buf_free (w_buf_free),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_res      (w_res),
        .o_last     (m_axis_tlast)
    );

    // Pack result fields onto the stream, lowest field first
    assign m_axis_tdata = {6'd0, w_res.error_position, w_res.failed, w_res.out_byte};
    assign m_axis_tuser = {w_res.string_done, w_res.has_byte};

endmodule

// ===== sv/msgesc_regs.sv =====
// APB-style configuration registers: decode mode and extra escape byte.
// Depends on msgesc_pkg.
module msgesc_regs
    import msgesc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_DECODE_MODE:  r_cfg.decode_mode  <= pwdata[0];
                REG_EXTRA_ESCAPE: r_cfg.extra_escape <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_DECODE_MODE:  prdata = {31'd0, r_cfg.decode_mode};
            REG_EXTRA_ESCAPE: prdata = {24'd0, r_cfg.extra_escape};
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== sv/msgesc_step.sv =====
// Input register, per-string state and the escape/unescape decision for one item.
// Produces a batch of up to three results. Depends on msgesc_pkg.
module msgesc_step
    import msgesc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_eos,
    input  logic       i_buf_free,
    output logic       o_load,
    output t_batch     o_batch
);

    logic             r_in_v;
    logic [7:0]       r_in_byte;
    logic             r_in_eos;
    logic             r_ap;
    logic             r_err;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_epos;

    logic             n_ap;
    logic             n_err;
    logic [POS_W-1:0] n_pos;
    logic [POS_W-1:0] n_epos;
    logic             w_proc;
    logic             w_ctrl;
    logic             w_follow_ok;
    logic [7:0]       w_shifted;

    assign w_proc  = r_in_v & i_buf_free;
    assign o_ready = ~r_in_v | w_proc;
    assign o_load  = w_proc;

    assign w_shifted   = i_cfg.extra_escape + CH_AT;
    assign w_ctrl      = (r_in_byte < CH_SPACE) ||
                         ((i_cfg.extra_escape != 8'd0) && (r_in_byte == i_cfg.extra_escape));
    assign w_follow_ok = ((r_in_byte > CH_AT) && (r_in_byte <= CH_UNDER)) ||
                         ((i_cfg.extra_escape != 8'd0) && (r_in_byte == w_shifted));

    always_comb begin
        n_ap    = r_ap;
        n_err   = r_err;
        n_epos  = r_epos;
        n_pos   = (r_pos < POS_CAP) ? r_pos + 1'b1 : r_pos;
        o_batch = '0;

        if (!r_err) begin
            if (!i_cfg.decode_mode) begin
                n_ap = 1'b0;
                if (w_ctrl) begin
                    o_batch.res[0] = data_result(CH_PCT);
                    o_batch.res[1] = data_result(r_in_byte + CH_AT);
                    o_batch.cnt    = 2'd2;
                end else if (r_in_byte == CH_PCT) begin
                    o_batch.res[0] = data_result(CH_PCT);
                    o_batch.res[1] = data_result(CH_PCT);
                    o_batch.cnt    = 2'd2;
                end else begin
                    o_batch.res[0] = data_result(r_in_byte);
                    o_batch.cnt    = 2'd1;
                end
            end else if (r_ap) begin
                n_ap = 1'b0;
                if (w_follow_ok) begin
                    o_batch.res[0] = data_result(r_in_byte - CH_AT);
                    o_batch.cnt    = 2'd1;
                end else if (r_in_byte == CH_PCT) begin
                    o_batch.res[0] = data_result(CH_PCT);
                    o_batch.cnt    = 2'd1;
                end else begin
                    n_err  = 1'b1;
                    n_epos = n_pos;
                end
            end else begin
                if (r_in_byte < CH_SPACE) begin
                    n_err  = 1'b1;
                    n_epos = n_pos;
                end else if (r_in_byte == CH_PCT) begin
                    n_ap = 1'b1;
                end else begin
                    o_batch.res[0] = data_result(r_in_byte);
                    o_batch.cnt    = 2'd1;
                end
            end
        end

        if (r_in_eos) begin
            // A lone percent at the end points one past the string
            if (!n_err && n_ap) begin
                n_err  = 1'b1;
                n_epos = (n_pos < POS_CAP) ? n_pos + 1'b1 : POS_CAP;
            end
            o_batch.res[o_batch.cnt] = status_result(n_err, n_err ? n_epos : '0);
            o_batch.cnt              = o_batch.cnt + 2'd1;
            n_ap   = 1'b0;
            n_err  = 1'b0;
            n_pos  = '0;
            n_epos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_ap   <= 1'b0;
            r_err  <= 1'b0;
            r_pos  <= '0;
            r_epos <= '0;
        end else begin
            if (o_ready) begin
                r_in_v <= i_valid;
            end
            if (w_proc) begin
                r_ap   <= n_ap;
                r_err  <= n_err;
                r_pos  <= n_pos;
                r_epos <= n_epos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte;
            r_in_eos  <= i_eos;
        end
    end

    a_err_clears_pct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> !r_ap) else $error("percent pending while error latched");
    a_pos_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_CAP) else $error("byte position beyond cap");
    a_epos_needs_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_err |-> (r_epos == '0)) else $error("error position without error");

endmodule

// ===== sv/msgesc_outbuf.sv =====
// Result buffer: holds one batch of up to three results and hands them out in order.
// Depends on msgesc_pkg.
module msgesc_outbuf
    import msgesc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_batch  i_batch,
    output logic    o_buf_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res,
    output logic    o_last
);

    t_result [NUM_SLOTS-1:0] r_slot;
    logic [1:0]              r_cnt;
    logic [1:0]              r_head;
    logic                    w_fire;
    logic                    w_last_take;

    assign o_valid     = (r_cnt != 2'd0);
    assign o_res       = r_slot[r_head];
    assign o_last      = (r_head == r_cnt - 2'd1);
    assign w_fire      = o_valid & i_ready;
    assign w_last_take = w_fire & o_last;
    assign o_buf_free  = ~o_valid | w_last_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_head <= 2'd0;
        end else if (i_load) begin
            r_cnt  <= i_batch.cnt;
            r_head <= 2'd0;
        end else if (w_last_take) begin
            r_cnt  <= 2'd0;
            r_head <= 2'd0;
        end else if (w_fire) begin
            r_head <= r_head + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_batch.res;
        end
    end

    a_head_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_head < r_cnt)) else $error("read pointer past batch");
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.string_done) |-> o_last) else $error("status not last of run");

endmodule

// ===== sim/msgesc_checker.sv =====
// Scoreboard for the message escape codec: tracks register writes, predicts the
// result stream for every accepted item and compares it with the output channel.
// Depends on msgesc_pkg for the result layout and character constants.
module msgesc_checker
    import msgesc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,
    input  logic [1:0]  i_m_tuser,
    input  logic        i_m_tlast,
    output int          o_mismatches,
    output int          o_pending
);

    typedef struct packed {
        t_result res;
        logic    last;
    } t_coded_result;

    t_cfg             cfg;
    logic             pct_pending;
    logic             err_seen;
    logic [POS_W-1:0] str_pos;
    logic [POS_W-1:0] first_err;
    t_coded_result    result_q[$];
    int               results_seen;

    function automatic t_coded_result data_item(input logic [7:0] b);
        t_coded_result r;
        r              = '0;
        r.res.out_byte = b;
        r.res.has_byte = 1'b1;
        return r;
    endfunction

    function automatic string describe(input t_coded_result r);
        return $sformatf("byte=%h has=%b done=%b fail=%b pos=%0d last=%b",
                         r.res.out_byte, r.res.has_byte, r.res.string_done,
                         r.res.failed, r.res.error_position, r.last);
    endfunction

    // Work out the results one input item causes and queue them.
    task automatic predict_results(input logic [7:0] b, input logic eos);
        t_coded_result    run [3];
        int               n;
        logic [7:0]       shifted;
        logic [POS_W-1:0] p;
        n = 0;
        if (str_pos < POS_CAP)
            str_pos = str_pos + 1'b1;
        if (!err_seen) begin
            if (!cfg.decode_mode) begin
                pct_pending = 1'b0;
                if (b < CH_SPACE || (cfg.extra_escape != 8'h00 && b == cfg.extra_escape)) begin
                    run[n++] = data_item(CH_PCT);
                    run[n++] = data_item(8'(b + CH_AT));
                end else if (b == CH_PCT) begin
                    run[n++] = data_item(CH_PCT);
                    run[n++] = data_item(CH_PCT);
                end else begin
                    run[n++] = data_item(b);
                end
            end else if (pct_pending) begin
                shifted     = 8'(cfg.extra_escape + CH_AT);
                pct_pending = 1'b0;
                if ((b > CH_AT && b <= CH_UNDER) ||
                    (cfg.extra_escape != 8'h00 && b == shifted)) begin
                    run[n++] = data_item(8'(b - CH_AT));
                end else if (b == CH_PCT) begin
                    run[n++] = data_item(CH_PCT);
                end else begin
                    err_seen  = 1'b1;
                    first_err = str_pos;
                end
            end else begin
                if (b < CH_SPACE) begin
                    err_seen  = 1'b1;
                    first_err = str_pos;
                end else if (b == CH_PCT) begin
                    pct_pending = 1'b1;
                end else begin
                    run[n++] = data_item(b);
                end
            end
        end
        if (eos) begin
            // a '%' left hanging at the end points one past the string
            if (!err_seen && pct_pending) begin
                p = str_pos + 1'b1;
                if (p > POS_CAP)
                    p = POS_CAP;
                err_seen  = 1'b1;
                first_err = p;
            end
            run[n]                    = '0;
            run[n].res.string_done    = 1'b1;
            run[n].res.failed         = err_seen;
            run[n].res.error_position = err_seen ? first_err : '0;
            n++;
            pct_pending = 1'b0;
            err_seen    = 1'b0;
            str_pos     = '0;
            first_err   = '0;
        end
        if (n > 0)
            run[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            result_q.push_back(run[k]);
    endtask

    task automatic check_result();
        t_coded_result got;
        t_coded_result want;
        got.res.out_byte       = i_m_tdata[7:0];
        got.res.failed         = i_m_tdata[8];
        got.res.error_position = i_m_tdata[25:9];
        got.res.has_byte       = i_m_tuser[0];
        got.res.string_done    = i_m_tuser[1];
        got.last               = i_m_tlast;
        if (result_q.size() == 0) begin
            if (o_mismatches < 10)
                $display("result %0d: none expected, got %s", results_seen, describe(got));
            o_mismatches++;
        end else begin
            want = result_q.pop_front();
            if (got.res.out_byte != want.res.out_byte ||
                got.res.has_byte != want.res.has_byte ||
                got.res.string_done != want.res.string_done ||
                got.res.failed != want.res.failed ||
                got.res.error_position != want.res.error_position ||
                got.last != want.last) begin
                if (o_mismatches < 10)
                    $display("result %0d: expected %s, got %s", results_seen,
                             describe(want), describe(got));
                o_mismatches++;
            end
        end
        results_seen++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg          = '0;
            pct_pending  = 1'b0;
            err_seen     = 1'b0;
            str_pos      = '0;
            first_err    = '0;
            results_seen = 0;
            o_mismatches = 0;
            result_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_DECODE_MODE)
                    cfg.decode_mode = i_pwdata[0];
                else
                    cfg.extra_escape = i_pwdata[7:0];
            end
            if (i_s_tvalid && i_s_tready)
                predict_results(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready)
                check_result();
        end
        o_pending = result_q.size();
    end

endmodule

// ===== sim/tb_message_escape_codec.sv =====
// Testbench top for the message escape codec: clock, reset, register writes and
// the input stream, with random idling on both channels and the final verdict.
// Depends on msgesc_pkg, message_escape_codec and msgesc_checker.
module tb_message_escape_codec;
    import msgesc_pkg::*;

    localparam int         CYCLE_LIMIT   = 1000000;
    localparam int         DRAIN_CYCLES  = 8;
    localparam int         RANDOM_ITEMS  = 145;
    localparam logic [2:0] ADDR_DECODE_MODE  = {REG_DECODE_MODE, 2'b00};
    localparam logic [2:0] ADDR_EXTRA_ESCAPE = {REG_EXTRA_ESCAPE, 2'b00};

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] in_byte
    logic        s_axis_tlast  = 1'b0; // end_of_string
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [7:0] out_byte, [8] failed, [25:9] error_position
    logic [1:0]  m_axis_tuser;         // [0] has_byte, [1] string_done
    logic        m_axis_tlast;         // last_of_run

    int   mismatches;
    int   pending;
    bit   calm = 1'b0;   // when set, neither side idles
    int   random_sent;
    logic cur_mode;
    logic [7:0] cur_extra;

    message_escape_codec DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    msgesc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tlast    (s_axis_tlast),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Draw the idle cycles before the next item on either side.
    function automatic int draw_wait();
        return calm ? 0 : int'($urandom_range(0, 19));
    endfunction

    // Offer one item and hold it until the block takes it. Keep tvalid high
    // afterwards so back-to-back items follow without tvalid dropping.
    task automatic send_item(input logic [7:0] b, input logic eos);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Two-phase register write: setup cycle, then access until pready.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drop tvalid, wait for every predicted result, then give items that
    // cause no result time to leave the pipeline.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic mode, input logic [7:0] extra);
        write_reg(ADDR_DECODE_MODE, {31'($urandom), mode});
        write_reg(ADDR_EXTRA_ESCAPE, {24'($urandom), extra});
        cur_mode  = mode;
        cur_extra = extra;
    endtask

    // One random string. Escape mode leans toward bytes that get stuffed;
    // unescape mode sends mostly well-formed sequences with a few broken ones.
    task automatic send_random_string(input int len);
        int         roll;
        logic       eos;
        logic [7:0] b;
        for (int k = 0; k < len; k++) begin
            eos  = (k == len - 1);
            roll = $urandom_range(0, 99);
            if (!cur_mode) begin
                if (roll < 30)
                    b = 8'($urandom_range(0, 31));
                else if (roll < 40)
                    b = CH_PCT;
                else if (roll < 50)
                    b = cur_extra;
                else
                    b = 8'($urandom);
                send_item(b, eos);
                random_sent++;
            end else if (roll < 45) begin
                b = 8'($urandom_range(32, 255));
                if (b == CH_PCT)
                    b = 8'h7E;
                send_item(b, eos);
                random_sent++;
            end else if (roll < 85) begin
                send_item(CH_PCT, 1'b0);
                case ($urandom_range(0, 3))
                    0:       b = CH_PCT;
                    1:       b = 8'(cur_extra + CH_AT);
                    default: b = 8'($urandom_range(65, 95));
                endcase
                send_item(b, eos);
                random_sent += 2;
            end else if (roll < 90) begin
                send_item(8'($urandom_range(0, 31)), eos);
                random_sent++;
            end else if (roll < 95) begin
                send_item(CH_PCT, 1'b0);
                send_item(8'($urandom), eos);
                random_sent += 2;
            end else begin
                // may leave a lone percent at the end of the string
                send_item(CH_PCT, eos);
                random_sent++;
            end
        end
    endtask

    // Output side: stall a random number of cycles before each result.
    initial begin
        int stall;
        @(posedge i_clk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        logic [7:0] extra;
        int         phase_end;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        cur_mode  = 1'b0;
        cur_extra = 8'h00;

        // Escape mode with reset registers: control extremes, space, percent, top byte.
        send_item(8'h00, 1'b0);
        send_item(8'h1F, 1'b0);
        send_item(CH_SPACE, 1'b0);
        send_item(CH_PCT, 1'b0);
        send_item(8'hFF, 1'b1);
        // leave the string open across the mode change
        send_item(CH_AT, 1'b0);
        drain();

        // Unescape with the top extra byte (shifted follower wraps to 0x3F).
        set_config(1'b1, 8'hFF);
        send_item(CH_PCT, 1'b0);
        send_item(8'h41, 1'b0);
        send_item(CH_PCT, 1'b0);
        send_item(CH_UNDER, 1'b0);
        send_item(CH_PCT, 1'b0);
        send_item(CH_PCT, 1'b0);
        send_item(CH_PCT, 1'b0);
        send_item(8'h3F, 1'b0);
        send_item(8'h7A, 1'b1);
        // bad follower, then the rest of the string is dropped
        send_item(CH_PCT, 1'b0);
        send_item(8'h60, 1'b0);
        send_item(8'h41, 1'b0);
        send_item(CH_PCT, 1'b1);
        // raw control byte
        send_item(8'h1F, 1'b1);
        // trailing lone percent
        send_item(8'h41, 1'b0);
        send_item(CH_PCT, 1'b1);
        // open percent, then an escape-mode byte must clear it
        send_item(CH_PCT, 1'b0);
        drain();
        set_config(1'b0, 8'hC5);
        send_item(8'hC5, 1'b0);
        send_item(8'h00, 1'b1);
        drain();

        // Random phases, each with its own settings and idling.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0:       extra = 8'h00;
                1:       extra = 8'hFF;
                2:       extra = 8'($urandom_range(0, 31));
                default: extra = 8'($urandom);
            endcase
            set_config(1'($urandom_range(0, 1)), extra);
            calm      = ($urandom_range(0, 3) == 0);
            phase_end = random_sent + $urandom_range(20, 40);
            while (random_sent < phase_end)
                send_random_string($urandom_range(1, 12));
            drain();
        end

        if (mismatches == 0 && pending == 0)
            $display("message_escape_codec: match");
        else
            $display("message_escape_codec: mismatch");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("message_escape_codec: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/msgesc_pkg.sv
sv/msgesc_regs.sv
sv/msgesc_step.sv
sv/msgesc_outbuf.sv
sv/message_escape_codec.sv
sim/msgesc_checker.sv
sim/tb_message_escape_codec.sv
